@@ rtl/core/rrmd_pkg.sv @@
// Shared types and constants of the row ridge marker detector.
// Used by every module in rtl/core; depends on nothing else.
package rrmd_pkg;

  localparam int PIX_W       = 12;
  localparam int COL_W       = 12;
  localparam int HW_W        = 5;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 12;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;

  localparam int DEF_MAX_HALF_WIDTH = 16;
  localparam int DEF_MAX_COLUMNS    = 4096;

  localparam logic [HW_W-1:0]  RST_HALF_WIDTH     = 5'd4;
  localparam logic [COL_W-1:0] RST_ROW_LENGTH     = 12'd640;
  localparam logic [PIX_W-1:0] RST_SLOPE_LIMIT    = 12'd48;
  localparam logic [PIX_W-1:0] RST_CONTRAST_LIMIT = 12'd320;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HALF_WIDTH     = 2'd0,
    CFG_ROW_LENGTH     = 2'd1,
    CFG_SLOPE_LIMIT    = 2'd2,
    CFG_CONTRAST_LIMIT = 2'd3
  } cfg_reg_e;

  // Local findings of one window cell.
  typedef struct packed {
    logic above;
    logic step_fail;
    logic low_left;
    logic low_right;
  } cell_flags_t;

  // Window-wide verdict handed to the sequencer.
  typedef struct packed {
    logic no_above;
    logic no_step_fail;
    logic any_low_left;
    logic any_low_right;
  } win_status_t;

endpackage

@@ rtl/core/row_ridge_marker_detector_top.sv @@
// Row ridge marker detector: configuration registers, column sequencer
// and output register. Uses rrmd_pkg and rrmd_window.
//
// Pixels of a row enter in column order, one per clock when results flow
// freely, and each produces the result for the column half_width places
// back, one result per clock through a single output register. The pixel
// at column half_width first produces zeros for columns 0 to half_width-1
// and then the evaluated result for column 0, half_width+1 results in all.
// The last pixel of a row adds the remaining columns up to its own, which
// is half_width more once the window has filled, so a pixel that is both
// produces 2*half_width+1 results. A pixel that produces results holds
// the input until its last one leaves. Pixels below column half_width
// produce no result unless they end the row. The window check runs in the
// cell chain in the cycle its result is written to the output register.
module row_ridge_marker_detector_top
  import rrmd_pkg::*;
#(
  parameter int MAX_HALF_WIDTH = DEF_MAX_HALF_WIDTH,
  parameter int MAX_COLUMNS    = DEF_MAX_COLUMNS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [11:0] pixel, rest zero
  input  logic                   s_axis_tuser,  // [0] row_valid
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // [11:0] column, rest zero
  output logic                   m_axis_tuser,  // [0] ridge
  output logic                   m_axis_tlast   // row_end
);

  localparam int CNT_W = $clog2(MAX_COLUMNS);
  localparam int CW    = ((CNT_W > COL_W) ? CNT_W : COL_W) + 2;

  logic [HW_W-1:0]  half_width_q;
  logic [COL_W-1:0] row_length_q;
  logic [PIX_W-1:0] slope_q;
  logic [PIX_W-1:0] contrast_q;
  logic [HW_W-1:0]  w_eff;

  logic [CNT_W-1:0] col_q;
  logic [CNT_W-1:0] col_d;
  logic [HW_W-1:0]  skip_q;
  logic [HW_W-1:0]  skip_d;

  logic             busy_q;
  logic             busy_d;
  logic [CNT_W-1:0] cur_q;
  logic [CNT_W-1:0] cur_d;
  logic [CNT_W-1:0] hi_q;
  logic [CNT_W-1:0] hi_d;
  logic [CNT_W-1:0] evcol_q;
  logic [CNT_W-1:0] evcol_d;
  logic             has_eval_q;
  logic             has_eval_d;
  logic             pre_q;
  logic             pre_d;
  logic             last_q;
  logic             last_d;
  logic             valid_q;
  logic             valid_d;

  logic             out_valid_q;
  logic             out_valid_d;
  logic             ridge_q;
  logic             ridge_d;
  logic [COL_W-1:0] column_q;
  logic [COL_W-1:0] column_d;
  logic             row_end_q;
  logic             row_end_d;

  logic             in_acc;
  logic             emit;
  logic             final_emit;
  logic             pre_end;
  logic             is_last;
  logic             ge_w;
  logic [HW_W:0]    span;
  logic             in_range;
  logic             eval_now;
  logic             hit;
  win_status_t      status;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_width_q <= RST_HALF_WIDTH;
      row_length_q <= RST_ROW_LENGTH;
      slope_q      <= RST_SLOPE_LIMIT;
      contrast_q   <= RST_CONTRAST_LIMIT;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_HALF_WIDTH:     half_width_q <= cfg_data_i[HW_W-1:0];
        CFG_ROW_LENGTH:     row_length_q <= cfg_data_i[COL_W-1:0];
        CFG_SLOPE_LIMIT:    slope_q      <= cfg_data_i[PIX_W-1:0];
        CFG_CONTRAST_LIMIT: contrast_q   <= cfg_data_i[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (half_width_q == '0) begin
      w_eff = HW_W'(1);
    end else if (half_width_q > HW_W'(MAX_HALF_WIDTH)) begin
      w_eff = HW_W'(MAX_HALF_WIDTH);
    end else begin
      w_eff = half_width_q;
    end
  end

  // Handshakes. A new pixel enters when idle or with the held pixel's last result.
  assign emit          = busy_q && (!out_valid_q || m_axis_tready);
  assign final_emit    = emit && !pre_q && (cur_q == hi_q);
  assign pre_end       = pre_q && (cur_q == CNT_W'(w_eff - HW_W'(1)));
  assign s_axis_tready = !busy_q || final_emit;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  rrmd_window #(
    .MAX_HALF_WIDTH(MAX_HALF_WIDTH)
  ) u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .shift_i     (in_acc),
    .pixel_i     (s_axis_tdata[PIX_W-1:0]),
    .half_width_i(w_eff),
    .slope_i     (slope_q),
    .contrast_i  (contrast_q),
    .status_o    (status)
  );

  // Column bookkeeping for the arriving pixel.
  assign is_last = (CW'(col_q) + CW'(1) >= CW'(row_length_q)) ||
                   (CW'(col_q) >= CW'(MAX_COLUMNS - 1));
  assign ge_w    = CW'(col_q) >= CW'(w_eff);

  // At column half_width the zero columns 0 to half_width-1 go out first,
  // then the sequencer returns to column 0 for its evaluation.
  always_comb begin
    evcol_d    = col_q - CNT_W'(w_eff);
    has_eval_d = ge_w;
    last_d     = is_last;
    valid_d    = s_axis_tuser;
    if (ge_w) begin
      cur_d  = (CW'(col_q) == CW'(w_eff)) ? '0 : evcol_d;
      pre_d  = CW'(col_q) == CW'(w_eff);
      hi_d   = is_last ? col_q : evcol_d;
      busy_d = 1'b1;
    end else begin
      cur_d  = '0;
      pre_d  = 1'b0;
      hi_d   = col_q;
      busy_d = is_last;
    end
    col_d = is_last ? '0 : col_q + CNT_W'(1);
  end

  // Ridge decision for the evaluated column.
  assign span     = {1'b0, w_eff} + {2'b0, w_eff[HW_W-1:1]};
  assign in_range = (CW'(evcol_q) >= CW'(span)) &&
                    (CW'(evcol_q) + CW'(span) + CW'(1) < CW'(row_length_q));
  assign eval_now = has_eval_q && !pre_q && (cur_q == evcol_q);
  assign hit      = (skip_q == '0) && valid_q && in_range && status.no_above &&
                    status.no_step_fail && status.any_low_left && status.any_low_right;

  always_comb begin
    skip_d = skip_q;
    if (emit && eval_now) begin
      if (skip_q != '0) begin
        skip_d = skip_q - HW_W'(1);
      end else if (hit) begin
        skip_d = w_eff;
      end
    end
    if (final_emit && last_q) begin
      skip_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      skip_q <= '0;
      busy_q <= 1'b0;
    end else begin
      skip_q <= skip_d;
      if (in_acc) begin
        col_q  <= col_d;
        busy_q <= busy_d;
      end else if (final_emit) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cur_q      <= cur_d;
      hi_q       <= hi_d;
      evcol_q    <= evcol_d;
      has_eval_q <= has_eval_d;
      pre_q      <= pre_d;
      last_q     <= last_d;
      valid_q    <= valid_d;
    end else if (emit) begin
      if (pre_end) begin
        cur_q <= evcol_q;
        pre_q <= 1'b0;
      end else begin
        cur_q <= cur_q + CNT_W'(1);
      end
    end
  end

  // Output register.
  always_comb begin
    ridge_d     = eval_now && hit;
    column_d    = COL_W'(cur_q);
    row_end_d   = last_q && !pre_q && (cur_q == hi_q);
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      ridge_q   <= ridge_d;
      column_q  <= column_d;
      row_end_q <= row_end_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'(column_q);
  assign m_axis_tuser  = ridge_q;
  assign m_axis_tlast  = row_end_q;

endmodule

@@ rtl/core/rrmd_cell.sv @@
// One cell of the pixel window: holds one pixel and checks it against
// the centre, the contrast threshold and its neighbor. Uses rrmd_pkg.
module rrmd_cell
  import rrmd_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             shift_i,
  input  logic [PIX_W-1:0] pixel_i,
  input  logic [PIX_W-1:0] nb_lo_i,
  input  logic [PIX_W-1:0] nb_hi_i,
  input  logic [HW_W-1:0]  half_width_i,
  input  logic [PIX_W-1:0] centre_i,
  input  logic [PIX_W-1:0] slope_i,
  input  logic [PIX_W-1:0] contrast_i,
  output logic [PIX_W-1:0] pixel_o,
  output cell_flags_t      flags_o
);

  logic [PIX_W-1:0] pixel_q;
  logic             in_win;
  logic             left_side;
  logic             right_side;
  logic [PIX_W-1:0] nb;
  logic [PIX_W:0]   nb_plus_slope;
  logic [PIX_W:0]   pix_plus_contrast;
  logic             low;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_q <= '0;
    end else if (shift_i) begin
      pixel_q <= pixel_i;
    end
  end

  // Index 0 is the newest pixel; the left flank lies on the older side.
  assign in_win     = IDX <= 2 * int'(half_width_i);
  assign left_side  = in_win && (IDX > int'(half_width_i));
  assign right_side = IDX < int'(half_width_i);

  // A left step looks at the next newer pixel, a right step at the next older one.
  assign nb                = left_side ? nb_lo_i : nb_hi_i;
  assign nb_plus_slope     = {1'b0, nb} + {1'b0, slope_i};
  assign pix_plus_contrast = {1'b0, pixel_q} + {1'b0, contrast_i};
  assign low               = pix_plus_contrast < {1'b0, centre_i};

  always_comb begin
    flags_o.above     = in_win && (pixel_q > centre_i);
    flags_o.step_fail = (left_side || right_side) && ({1'b0, pixel_q} >= nb_plus_slope);
    flags_o.low_left  = left_side && low;
    flags_o.low_right = right_side && low;
  end

  assign pixel_o = pixel_q;

endmodule

@@ rtl/core/rrmd_window.sv @@
// Shift chain of window cells with the centre register and the reduction
// of the cell findings. Uses rrmd_pkg and rrmd_cell.
module rrmd_window
  import rrmd_pkg::*;
#(
  parameter int MAX_HALF_WIDTH = DEF_MAX_HALF_WIDTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             shift_i,
  input  logic [PIX_W-1:0] pixel_i,
  input  logic [HW_W-1:0]  half_width_i,
  input  logic [PIX_W-1:0] slope_i,
  input  logic [PIX_W-1:0] contrast_i,
  output win_status_t      status_o
);

  localparam int DEPTH = 2 * MAX_HALF_WIDTH + 1;
  localparam int IW    = $clog2(DEPTH);

  logic [PIX_W-1:0] pix [DEPTH];
  cell_flags_t      flags [DEPTH];
  logic [DEPTH-1:0] above_v;
  logic [DEPTH-1:0] step_v;
  logic [DEPTH-1:0] low_left_v;
  logic [DEPTH-1:0] low_right_v;
  logic [PIX_W-1:0] centre_q;

  // After a shift the centre is the pixel one place newer than it is now.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      centre_q <= '0;
    end else if (shift_i) begin
      centre_q <= pix[IW'(half_width_i - 5'd1)];
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [PIX_W-1:0] shift_in;
    logic [PIX_W-1:0] nb_lo;
    logic [PIX_W-1:0] nb_hi;

    if (i == 0) begin : g_first
      assign shift_in = pixel_i;
      assign nb_lo    = '0;
    end else begin : g_mid
      assign shift_in = pix[i-1];
      assign nb_lo    = pix[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign nb_hi = '0;
    end else begin : g_body
      assign nb_hi = pix[i+1];
    end

    rrmd_cell #(
      .IDX(i)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .shift_i     (shift_i),
      .pixel_i     (shift_in),
      .nb_lo_i     (nb_lo),
      .nb_hi_i     (nb_hi),
      .half_width_i(half_width_i),
      .centre_i    (centre_q),
      .slope_i     (slope_i),
      .contrast_i  (contrast_i),
      .pixel_o     (pix[i]),
      .flags_o     (flags[i])
    );

    assign above_v[i]     = flags[i].above;
    assign step_v[i]      = flags[i].step_fail;
    assign low_left_v[i]  = flags[i].low_left;
    assign low_right_v[i] = flags[i].low_right;
  end

  always_comb begin
    status_o.no_above      = ~|above_v;
    status_o.no_step_fail  = ~|step_v;
    status_o.any_low_left  = |low_left_v;
    status_o.any_low_right = |low_right_v;
  end

endmodule

@@ rtl/core/rrmd_checker.sv @@
// Port-level checks of the row ridge marker detector, bound to its top level.
// Uses rrmd_pkg; attaches to row_ridge_marker_detector_top.
module rrmd_checker
  import rrmd_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                   m_axis_tuser,
  input logic                   m_axis_tlast
);

  // A stalled request keeps its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("output request changed while stalled");

  // A ridge centre is at least one half-width away from the row end.
  a_ridge_not_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> !m_axis_tlast)
    else $error("ridge flagged on the last column of a row");

  // The lowest ridge column is never zero.
  a_ridge_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[COL_W-1:0] != '0)
    else $error("ridge flagged at column zero");

  // The columns after a hit are suppressed, so two ridges never follow directly.
  a_ridge_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tuser |=>
      !(m_axis_tvalid && m_axis_tuser))
    else $error("two adjacent ridge results");

endmodule

bind row_ridge_marker_detector_top rrmd_checker u_rrmd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .m_axis_tlast (m_axis_tlast)
);
